/* hw/rtl/json_string_escaper_defines.svh */
// assertion macros for the asserting file, the top level json_string_escaper.sv
`ifndef JSON_STRING_ESCAPER_DEFINES_SVH
`define JSON_STRING_ESCAPER_DEFINES_SVH

// checked on every rising edge outside reset
`define JSE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define JSE_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/jse_pkg.sv */
package jse_pkg;

	// characters of the literal
	localparam logic [7:0] QuoteChar  = 8'h22;
	localparam logic [7:0] BslashChar = 8'h5C;
	localparam logic [7:0] SlashChar  = 8'h2F;
	localparam logic [7:0] LetterU    = 8'h75;
	localparam logic [7:0] DigitZero  = 8'h30;
	localparam logic [7:0] CtrlMax    = 8'h1F;

	// control codes with a short escape
	localparam logic [7:0] CodeBackspace = 8'h08;
	localparam logic [7:0] CodeTab       = 8'h09;
	localparam logic [7:0] CodeLineFeed  = 8'h0A;
	localparam logic [7:0] CodeFormFeed  = 8'h0C;
	localparam logic [7:0] CodeReturn    = 8'h0D;

	// their escape letters
	localparam logic [7:0] LetterB = 8'h62;
	localparam logic [7:0] LetterT = 8'h74;
	localparam logic [7:0] LetterN = 8'h6E;
	localparam logic [7:0] LetterF = 8'h66;
	localparam logic [7:0] LetterR = 8'h72;

	// longest run of output bytes for one transaction
	localparam int MaxRun = 8;

	// default depth of the descriptor queue
	localparam int QueueDepth = 4;

	// one classified transaction: its output bytes and run length less one
	typedef struct packed {
		logic [MaxRun-1:0][7:0] seq;
		logic [2:0]             lenm1;
		logic                   close;
	} jse_desc_t;

	// queue status seen by the top level
	typedef struct packed {
		logic full;
		logic empty;
	} jse_q_status_t;

	// upper-case hex digit of a nibble
	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] d;
		if (nib < 4'd10) begin
			d = DigitZero + {4'h0, nib};
		end else begin
			d = 8'h37 + {4'h0, nib};
		end
		return d;
	endfunction

endpackage

/* hw/rtl/jse_front.sv */
module jse_front (
	input  logic              [7:0] in_byte,
	input  logic                    first_of_string,
	input  logic                    last_of_string,
	input  logic                    no_byte,
	output jse_pkg::jse_desc_t      desc,
	output logic                    desc_valid
);
	import jse_pkg::*;

	logic [7:0][7:0] esc;
	logic [3:0]      esc_len;
	logic [7:0]      letter;
	logic [3:0]      off;
	logic [3:0]      run_len;
	logic [3:0]      j;

	// escape sequence of the raw byte
	always_comb begin
		esc     = '0;
		esc_len = 4'd0;
		letter  = 8'h00;
		case (in_byte)
			CodeBackspace: letter = LetterB;
			CodeTab:       letter = LetterT;
			CodeLineFeed:  letter = LetterN;
			CodeFormFeed:  letter = LetterF;
			CodeReturn:    letter = LetterR;
			default:       letter = 8'h00;
		endcase
		if (!no_byte) begin
			if (in_byte <= CtrlMax) begin
				esc[0] = BslashChar;
				if (letter != 8'h00) begin
					esc[1]  = letter;
					esc_len = 4'd2;
				end else begin
					esc[1]  = LetterU;
					esc[2]  = DigitZero;
					esc[3]  = DigitZero;
					esc[4]  = hex_digit(in_byte[7:4]);
					esc[5]  = hex_digit(in_byte[3:0]);
					esc_len = 4'd6;
				end
			end else if (in_byte == QuoteChar || in_byte == BslashChar
					|| in_byte == SlashChar) begin
				esc[0]  = BslashChar;
				esc[1]  = in_byte;
				esc_len = 4'd2;
			end else begin
				esc[0]  = in_byte;
				esc_len = 4'd1;
			end
		end
	end

	// total bytes of the run, quotes included
	assign run_len = {3'b000, first_of_string} + esc_len + {3'b000, last_of_string};

	// place the quotes around the escape
	always_comb begin
		off        = {3'b000, first_of_string};
		j          = 4'd0;
		desc.lenm1 = 3'(run_len - 4'd1);
		desc.close = last_of_string;
		for (int i = 0; i < MaxRun; i++) begin
			j = 4'(i) - off;
			if (first_of_string && i == 0) begin
				desc.seq[i] = QuoteChar;
			end else if (j < esc_len) begin
				desc.seq[i] = esc[j[2:0]];
			end else begin
				desc.seq[i] = QuoteChar;
			end
		end
	end

	assign desc_valid = (run_len != 4'd0);

endmodule

/* hw/rtl/jse_queue.sv */
module jse_queue #(
	parameter int Depth = jse_pkg::QueueDepth
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  jse_pkg::jse_desc_t      push_desc,
	input  logic                    pop,
	output jse_pkg::jse_desc_t      head_desc,
	output jse_pkg::jse_q_status_t  status
);
	import jse_pkg::*;

	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW  = $clog2(Depth + 1);

	jse_desc_t        mem_q [Depth];
	logic [AddrW-1:0] wr_ptr_q;
	logic [AddrW-1:0] rd_ptr_q;
	logic [CntW-1:0]  count_q;

	// storage for queued descriptors
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head_desc    = mem_q[rd_ptr_q];
	assign status.full  = (count_q == CntW'(Depth));
	assign status.empty = (count_q == '0);

endmodule

/* hw/rtl/jse_back.sv */
module jse_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    head_valid,
	input  jse_pkg::jse_desc_t      head_desc,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic              [7:0] out_byte,
	output logic                    last_of_run,
	output logic                    literal_done
);
	import jse_pkg::*;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_of_run_q;
	logic       literal_done_q;
	logic [2:0] idx_q;
	logic       load;
	logic       run_end;

	// next byte moves into the output register when it is free
	assign load    = head_valid && (!out_valid_q || !out_stall);
	assign run_end = (idx_q == head_desc.lenm1);
	assign pop     = load && run_end;

	// position within the current run, and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= run_end ? '0 : idx_q + 1'b1;
			end
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= head_valid;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q     <= head_desc.seq[idx_q];
			last_of_run_q  <= run_end;
			literal_done_q <= run_end && head_desc.close;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign last_of_run  = last_of_run_q;
	assign literal_done = literal_done_q;

endmodule

/* hw/rtl/json_string_escaper.sv */
// JSON string literal escaper. Raw string bytes enter one transaction per cycle while
// in_stall is low and leave as the bytes of the escaped literal, one byte per cycle while
// out_stall is low; a transaction gives one to eight output bytes (quotes, a two-byte
// escape or a six-byte \u00XX form). The output serialiser sets the sustained input rate;
// a queue of QueueDepth classified transactions lets input flow on while a long escape
// drains, and in_stall rises only when that queue is full. An accepted transaction passes
// through the queue memory and the output register before its first byte shows. A
// transaction with no_byte set and neither quote flag gives no output.
`include "json_string_escaper_defines.svh"

module json_string_escaper #(
	parameter int QueueDepth = jse_pkg::QueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       first_of_string,
	input  logic       last_of_string,
	input  logic       no_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last_of_run,
	output logic       literal_done
);
	import jse_pkg::*;

	jse_desc_t     front_desc;
	logic          front_valid;
	jse_desc_t     head_desc;
	jse_q_status_t q_status;
	logic          push;
	logic          pop;

	// classify each transaction
	jse_front u_front (
		.in_byte         (in_byte),
		.first_of_string (first_of_string),
		.last_of_string  (last_of_string),
		.no_byte         (no_byte),
		.desc            (front_desc),
		.desc_valid      (front_valid)
	);

	assign in_stall = q_status.full;
	assign push     = in_valid && !q_status.full && front_valid;

	// descriptor queue between front and back
	jse_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (front_desc),
		.pop       (pop),
		.head_desc (head_desc),
		.status    (q_status)
	);

	// serialise runs onto the output
	jse_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (!q_status.empty),
		.head_desc    (head_desc),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.last_of_run  (last_of_run),
		.literal_done (literal_done)
	);

	// checks
	`JSE_ASSERT(a_done_is_quote, (out_valid && literal_done) |-> (last_of_run && out_byte == QuoteChar), "literal end not on a closing quote")
	`JSE_ASSERT(a_no_overflow, q_status.full |-> !push, "push into a full queue")
	`JSE_ASSERT(a_pop_needs_head, pop |-> !q_status.empty, "pop from an empty queue")
	`JSE_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> (!out_valid && q_status.empty), "output or queue busy in reset")

endmodule
